### hdl/chb_pkg.sv
package chb_pkg;

    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_COORD_WIDTH = 32;

    // configuration register map
    localparam int NUM_REGS          = 8;
    localparam int REG_SEL_WIDTH     = 3;
    localparam int CFG_INDEX_WIDTH   = 4;
    localparam int REG_START_X       = 0;
    localparam int REG_START_Y       = 1;
    localparam int REG_START_TAN_X   = 2;
    localparam int REG_START_TAN_Y   = 3;
    localparam int REG_END_X         = 4;
    localparam int REG_END_Y         = 5;
    localparam int REG_END_TAN_X     = 6;
    localparam int REG_END_TAN_Y     = 7;

    // basis weight layout: kind x term
    localparam int NUM_KINDS      = 3;
    localparam int NUM_TERMS      = 4;
    localparam int KIND_POS       = 0;
    localparam int KIND_VEL       = 1;
    localparam int KIND_ACCEL     = 2;
    localparam int TERM_START     = 0;
    localparam int TERM_START_TAN = 1;
    localparam int TERM_END       = 2;
    localparam int TERM_END_TAN   = 3;

    localparam int NUM_STAGES = 7;

    // per-stage load enables, one per pipeline register stage
    typedef struct packed {
        logic clamp;
        logic square;
        logic cube;
        logic basis;
        logic product;
        logic sum;
        logic result;
    } stage_en_t;

endpackage

### hdl/chb_param.sv
module chb_param #(
    parameter int FRAC_BITS = chb_pkg::DEF_FRAC_BITS
) (
    input  logic                  clk,
    input  chb_pkg::stage_en_t    en,
    input  logic [FRAC_BITS:0]    curve_param,
    output logic [FRAC_BITS:0]    t_out,
    output logic [FRAC_BITS:0]    t2_out,
    output logic [FRAC_BITS:0]    t3_out
);

    localparam int TW = FRAC_BITS + 1;
    localparam int PW = 2 * TW;
    localparam logic [TW-1:0] ONE  = TW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    logic [TW-1:0] t_reg, t_next;
    logic [TW-1:0] t_d2_reg, t2_reg, t2_next;
    logic [TW-1:0] t_d3_reg, t2_d3_reg, t3_reg, t3_next;
    logic [PW-1:0] sq_full, cu_full;

    always_comb
    begin
        // t above 1.0 is clamped to 1.0
        t_next  = (curve_param > ONE) ? ONE : curve_param;
        sq_full = PW'(t_reg) * PW'(t_reg) + HALF;
        t2_next = sq_full[FRAC_BITS +: TW];
        cu_full = PW'(t2_reg) * PW'(t_d2_reg) + HALF;
        t3_next = cu_full[FRAC_BITS +: TW];
    end

    always_ff @(posedge clk)
    begin
        if (en.clamp)
        begin
            t_reg <= t_next;
        end
        if (en.square)
        begin
            t2_reg   <= t2_next;
            t_d2_reg <= t_reg;
        end
        if (en.cube)
        begin
            t3_reg    <= t3_next;
            t2_d3_reg <= t2_reg;
            t_d3_reg  <= t_d2_reg;
        end
    end

    assign t_out  = t_d3_reg;
    assign t2_out = t2_d3_reg;
    assign t3_out = t3_reg;

endmodule

### hdl/chb_basis.sv
module chb_basis #(
    parameter int FRAC_BITS = chb_pkg::DEF_FRAC_BITS
) (
    input  logic                      clk,
    input  chb_pkg::stage_en_t        en,
    input  logic [FRAC_BITS:0]        t_in,
    input  logic [FRAC_BITS:0]        t2_in,
    input  logic [FRAC_BITS:0]        t3_in,
    output logic signed [FRAC_BITS+4:0] weight [chb_pkg::NUM_KINDS][chb_pkg::NUM_TERMS]
);

    localparam int WW = FRAC_BITS + 5;
    localparam logic signed [WW-1:0] K2   = WW'(2);
    localparam logic signed [WW-1:0] K3   = WW'(3);
    localparam logic signed [WW-1:0] K4   = WW'(4);
    localparam logic signed [WW-1:0] K6   = WW'(6);
    localparam logic signed [WW-1:0] K12  = WW'(12);
    localparam logic signed [WW-1:0] ONE  = WW'(1) <<< FRAC_BITS;

    logic signed [WW-1:0] ts, t2s, t3s;
    logic signed [WW-1:0] weight_next [chb_pkg::NUM_KINDS][chb_pkg::NUM_TERMS];
    logic signed [WW-1:0] weight_reg  [chb_pkg::NUM_KINDS][chb_pkg::NUM_TERMS];

    always_comb
    begin
        ts  = WW'(t_in);
        t2s = WW'(t2_in);
        t3s = WW'(t3_in);

        weight_next[chb_pkg::KIND_POS][chb_pkg::TERM_START]     = K2 * t3s - K3 * t2s + ONE;
        weight_next[chb_pkg::KIND_POS][chb_pkg::TERM_START_TAN] = t3s - K2 * t2s + ts;
        weight_next[chb_pkg::KIND_POS][chb_pkg::TERM_END]       = K3 * t2s - K2 * t3s;
        weight_next[chb_pkg::KIND_POS][chb_pkg::TERM_END_TAN]   = t3s - t2s;

        weight_next[chb_pkg::KIND_VEL][chb_pkg::TERM_START]     = K6 * t2s - K6 * ts;
        weight_next[chb_pkg::KIND_VEL][chb_pkg::TERM_START_TAN] = K3 * t2s - K4 * ts + ONE;
        weight_next[chb_pkg::KIND_VEL][chb_pkg::TERM_END]       = K6 * ts - K6 * t2s;
        weight_next[chb_pkg::KIND_VEL][chb_pkg::TERM_END_TAN]   = K3 * t2s - K2 * ts;

        weight_next[chb_pkg::KIND_ACCEL][chb_pkg::TERM_START]     = K12 * ts - K6 * ONE;
        weight_next[chb_pkg::KIND_ACCEL][chb_pkg::TERM_START_TAN] = K6 * ts - K4 * ONE;
        weight_next[chb_pkg::KIND_ACCEL][chb_pkg::TERM_END]       = K6 * ONE - K12 * ts;
        weight_next[chb_pkg::KIND_ACCEL][chb_pkg::TERM_END_TAN]   = K6 * ts - K2 * ONE;
    end

    always_ff @(posedge clk)
    begin
        if (en.basis)
        begin
            weight_reg <= weight_next;
        end
    end

    assign weight = weight_reg;

endmodule

### hdl/chb_axis.sv
module chb_axis #(
    parameter int FRAC_BITS   = chb_pkg::DEF_FRAC_BITS,
    parameter int COORD_WIDTH = chb_pkg::DEF_COORD_WIDTH
) (
    input  logic                          clk,
    input  chb_pkg::stage_en_t            en,
    input  logic signed [FRAC_BITS+4:0]   weight [chb_pkg::NUM_KINDS][chb_pkg::NUM_TERMS],
    input  logic signed [COORD_WIDTH-1:0] start_pt,
    input  logic signed [COORD_WIDTH-1:0] start_tan,
    input  logic signed [COORD_WIDTH-1:0] end_pt,
    input  logic signed [COORD_WIDTH-1:0] end_tan,
    output logic signed [COORD_WIDTH-1:0] pos,
    output logic signed [COORD_WIDTH-1:0] vel,
    output logic signed [COORD_WIDTH-1:0] accel
);

    localparam int WW = FRAC_BITS + 5;
    localparam int PW = COORD_WIDTH + WW;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] SAT_MAX =
        {{(SW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [COORD_WIDTH-1:0] coef [chb_pkg::NUM_TERMS];
    logic signed [PW-1:0] prod_next [chb_pkg::NUM_KINDS][chb_pkg::NUM_TERMS];
    logic signed [PW-1:0] prod_reg  [chb_pkg::NUM_KINDS][chb_pkg::NUM_TERMS];
    logic signed [SW-1:0] sum_next  [chb_pkg::NUM_KINDS];
    logic signed [SW-1:0] sum_reg   [chb_pkg::NUM_KINDS];
    logic signed [SW-1:0] shifted   [chb_pkg::NUM_KINDS];
    logic signed [COORD_WIDTH-1:0] res_next [chb_pkg::NUM_KINDS];
    logic signed [COORD_WIDTH-1:0] res_reg  [chb_pkg::NUM_KINDS];

    always_comb
    begin
        coef[chb_pkg::TERM_START]     = start_pt;
        coef[chb_pkg::TERM_START_TAN] = start_tan;
        coef[chb_pkg::TERM_END]       = end_pt;
        coef[chb_pkg::TERM_END_TAN]   = end_tan;
        for (int k = 0; k < chb_pkg::NUM_KINDS; k++)
        begin
            for (int j = 0; j < chb_pkg::NUM_TERMS; j++)
            begin
                prod_next[k][j] = PW'(coef[j]) * PW'(weight[k][j]);
            end
            // exact sum plus half an lsb: floor after the shift rounds ties up
            sum_next[k] = SW'(prod_reg[k][0]) + SW'(prod_reg[k][1])
                        + SW'(prod_reg[k][2]) + SW'(prod_reg[k][3]) + HALF;
            shifted[k] = sum_reg[k] >>> FRAC_BITS;
            if (shifted[k] > SAT_MAX)
            begin
                res_next[k] = SAT_MAX[COORD_WIDTH-1:0];
            end
            else if (shifted[k] < SAT_MIN)
            begin
                res_next[k] = SAT_MIN[COORD_WIDTH-1:0];
            end
            else
            begin
                res_next[k] = shifted[k][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.product)
        begin
            prod_reg <= prod_next;
        end
        if (en.sum)
        begin
            sum_reg <= sum_next;
        end
        if (en.result)
        begin
            res_reg <= res_next;
        end
    end

    assign pos   = res_reg[chb_pkg::KIND_POS];
    assign vel   = res_reg[chb_pkg::KIND_VEL];
    assign accel = res_reg[chb_pkg::KIND_ACCEL];

endmodule

### hdl/cubic_hermite_evaluator.sv
// Evaluates one 2D cubic Hermite segment at a curve parameter t (unsigned, one integer
// bit, FRAC_BITS fraction bits; values above 1.0 are clamped to 1.0) and returns position,
// first and second derivative for x and y in signed fixed point with 16 fraction bits,
// rounded to nearest (ties up) and saturated. The segment (start point, start tangent, end
// point, end tangent) is written through cfg_we/cfg_index/cfg_data; the user must write it
// only while no request is in flight, which the block does not enforce; indexes 8 and above
// are ignored. The datapath is a seven-stage pipeline (clamp, t squared, t cubed, basis
// weights, products, sum, round and saturate): it accepts one request per clock unless every
// stage is full and out_ready is low. Each stage holds only while its successor is full and
// stalled, so empty stages keep taking requests while a finished result waits at the output.
module cubic_hermite_evaluator #(
    parameter int FRAC_BITS   = chb_pkg::DEF_FRAC_BITS,
    parameter int COORD_WIDTH = chb_pkg::DEF_COORD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [chb_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [COORD_WIDTH-1:0]               cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [FRAC_BITS:0]                   curve_param,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [COORD_WIDTH-1:0]        pos_x,
    output logic signed [COORD_WIDTH-1:0]        pos_y,
    output logic signed [COORD_WIDTH-1:0]        vel_x,
    output logic signed [COORD_WIDTH-1:0]        vel_y,
    output logic signed [COORD_WIDTH-1:0]        accel_x,
    output logic signed [COORD_WIDTH-1:0]        accel_y
);

    localparam int NS = chb_pkg::NUM_STAGES;
    localparam int IW = chb_pkg::CFG_INDEX_WIDTH;

    logic signed [COORD_WIDTH-1:0] coord_reg [chb_pkg::NUM_REGS];
    logic [NS-1:0] valid_reg, valid_next, stage_go;
    chb_pkg::stage_en_t en;

    logic [FRAC_BITS:0] t_s3, t2_s3, t3_s3;
    logic signed [FRAC_BITS+4:0] weight [chb_pkg::NUM_KINDS][chb_pkg::NUM_TERMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < chb_pkg::NUM_REGS; i++)
            begin
                coord_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < IW'(chb_pkg::NUM_REGS)))
        begin
            coord_reg[cfg_index[chb_pkg::REG_SEL_WIDTH-1:0]] <= cfg_data;
        end
    end

    // a stage loads when it is empty or its successor loads
    always_comb
    begin
        stage_go[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_go[k] = !valid_reg[k] || stage_go[k+1];
        end
        valid_next = {valid_reg[NS-2:0], in_valid};
    end

    assign en.clamp   = stage_go[0];
    assign en.square  = stage_go[1];
    assign en.cube    = stage_go[2];
    assign en.basis   = stage_go[3];
    assign en.product = stage_go[4];
    assign en.sum     = stage_go[5];
    assign en.result  = stage_go[6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (stage_go[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign in_ready  = stage_go[0];
    assign out_valid = valid_reg[NS-1];

    chb_param #(
        .FRAC_BITS (FRAC_BITS)
    ) u_param (
        .clk         (clk),
        .en          (en),
        .curve_param (curve_param),
        .t_out       (t_s3),
        .t2_out      (t2_s3),
        .t3_out      (t3_s3)
    );

    chb_basis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_basis (
        .clk    (clk),
        .en     (en),
        .t_in   (t_s3),
        .t2_in  (t2_s3),
        .t3_in  (t3_s3),
        .weight (weight)
    );

    chb_axis #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_axis_x (
        .clk       (clk),
        .en        (en),
        .weight    (weight),
        .start_pt  (coord_reg[chb_pkg::REG_START_X]),
        .start_tan (coord_reg[chb_pkg::REG_START_TAN_X]),
        .end_pt    (coord_reg[chb_pkg::REG_END_X]),
        .end_tan   (coord_reg[chb_pkg::REG_END_TAN_X]),
        .pos       (pos_x),
        .vel       (vel_x),
        .accel     (accel_x)
    );

    chb_axis #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_axis_y (
        .clk       (clk),
        .en        (en),
        .weight    (weight),
        .start_pt  (coord_reg[chb_pkg::REG_START_Y]),
        .start_tan (coord_reg[chb_pkg::REG_START_TAN_Y]),
        .end_pt    (coord_reg[chb_pkg::REG_END_Y]),
        .end_tan   (coord_reg[chb_pkg::REG_END_TAN_Y]),
        .pos       (pos_y),
        .vel       (vel_y),
        .accel     (accel_y)
    );

endmodule

### hdl/chb_checker.sv
module chb_checker #(
    parameter int COORD_WIDTH = chb_pkg::DEF_COORD_WIDTH
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [COORD_WIDTH-1:0] pos_x,
    input logic [COORD_WIDTH-1:0] pos_y,
    input logic [COORD_WIDTH-1:0] vel_x,
    input logic [COORD_WIDTH-1:0] vel_y,
    input logic [COORD_WIDTH-1:0] accel_x,
    input logic [COORD_WIDTH-1:0] accel_y
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pos_x) && $stable(pos_y) && $stable(vel_x)
            && $stable(vel_y) && $stable(accel_x) && $stable(accel_y))
        else $error("result changed while stalled");

    // the pipeline only refuses a request while a result waits stalled at the output
    assert property (@(posedge clk)
        !in_ready |-> out_valid && !out_ready)
        else $error("request refused with room in the pipeline");

    // in reset the pipeline offers no result and takes requests
    assert property (@(posedge clk)
        !rst_n |=> !out_valid && in_ready)
        else $error("pipeline not empty in reset");

endmodule

bind cubic_hermite_evaluator chb_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_chb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .accel_x   (accel_x),
    .accel_y   (accel_y)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int FRAC        = chb_pkg::DEF_FRAC_BITS;
    localparam int CW          = chb_pkg::DEF_COORD_WIDTH;
    localparam int IDX_W       = chb_pkg::CFG_INDEX_WIDTH;
    localparam int PARAM_W     = FRAC + 1;
    localparam int PARAM_ONE   = 1 << FRAC;
    localparam int PARAM_MAX   = (1 << PARAM_W) - 1;
    localparam int INDEX_MAX   = (1 << chb_pkg::CFG_INDEX_WIDTH) - 1;
    localparam longint UNIT    = longint'(1) << FRAC;
    localparam longint SAT_MAX = (longint'(1) << (CW - 1)) - 1;
    localparam longint SAT_MIN = -SAT_MAX - 1;
    localparam logic [CW-1:0] COORD_HI = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COORD_LO = {1'b1, {(CW-1){1'b0}}};
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES   = chb_pkg::NUM_STAGES + 3;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct packed {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] vel_x;
        logic signed [CW-1:0] vel_y;
        logic signed [CW-1:0] accel_x;
        logic signed [CW-1:0] accel_y;
    } curve_point_t;

    typedef enum logic { ROW_WRITE, ROW_ITEM } row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [chb_pkg::CFG_INDEX_WIDTH-1:0] idx;
        logic [CW-1:0]                      data;
        logic [PARAM_W-1:0]                 param;
        logic                               typed;
        curve_point_t                       want;
    } stim_row_t;

    typedef enum { READY_FREE, READY_COIN, READY_SPARSE, READY_PERIODIC } ready_mode_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [chb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CW-1:0]                       cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic [PARAM_W-1:0]                  curve_param;
    logic                                out_valid;
    logic                                out_ready;
    logic signed [CW-1:0]                pos_x;
    logic signed [CW-1:0]                pos_y;
    logic signed [CW-1:0]                vel_x;
    logic signed [CW-1:0]                vel_y;
    logic signed [CW-1:0]                accel_x;
    logic signed [CW-1:0]                accel_y;

    logic signed [CW-1:0] segment_regs [chb_pkg::NUM_REGS];
    curve_point_t         expected_points [$];
    stim_row_t            stim_rows [$];
    int                   mismatch_count;
    int                   cycle_count;

    cubic_hermite_evaluator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .curve_param(curve_param),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .accel_x    (accel_x),
        .accel_y    (accel_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // sum of the four control values of one axis under the given weights, then scaled down by UNIT
    function automatic logic [CW-1:0] blend_axis(input int axis, input longint w0,
                                                  input longint w1, input longint w2,
                                                  input longint w3);
        longint weights [4];
        longint coef;
        longint acc_int;
        longint acc_frac;
        longint total;
        weights[0] = w0;
        weights[1] = w1;
        weights[2] = w2;
        weights[3] = w3;
        acc_int = 0;
        acc_frac = 0;
        for (int term = 0; term < 4; term++)
        begin
            coef = longint'(segment_regs[chb_pkg::REG_START_X + 2 * term + axis]);
            acc_int += (coef >>> FRAC) * weights[term];
            acc_frac += (coef & (UNIT - 1)) * weights[term];
        end
        // one rounding of the whole sum, ties upward
        total = acc_int + ((acc_frac + UNIT / 2) >>> FRAC);
        if (total > SAT_MAX)
            total = SAT_MAX;
        if (total < SAT_MIN)
            total = SAT_MIN;
        return total[CW-1:0];
    endfunction

    function automatic curve_point_t evaluate_segment(input logic [PARAM_W-1:0] param);
        longint t;
        longint t2;
        longint t3;
        longint wp [4];
        longint wv [4];
        longint wa [4];
        curve_point_t pt;
        t = (longint'(param) > UNIT) ? UNIT : longint'(param);
        t2 = (t * t + UNIT / 2) >>> FRAC;
        t3 = (t2 * t + UNIT / 2) >>> FRAC;
        wp[0] = 2 * t3 - 3 * t2 + UNIT;
        wp[1] = t3 - 2 * t2 + t;
        wp[2] = -2 * t3 + 3 * t2;
        wp[3] = t3 - t2;
        wv[0] = 6 * t2 - 6 * t;
        wv[1] = 3 * t2 - 4 * t + UNIT;
        wv[2] = -6 * t2 + 6 * t;
        wv[3] = 3 * t2 - 2 * t;
        wa[0] = 12 * t - 6 * UNIT;
        wa[1] = 6 * t - 4 * UNIT;
        wa[2] = -12 * t + 6 * UNIT;
        wa[3] = 6 * t - 2 * UNIT;
        pt.pos_x   = blend_axis(0, wp[0], wp[1], wp[2], wp[3]);
        pt.pos_y   = blend_axis(1, wp[0], wp[1], wp[2], wp[3]);
        pt.vel_x   = blend_axis(0, wv[0], wv[1], wv[2], wv[3]);
        pt.vel_y   = blend_axis(1, wv[0], wv[1], wv[2], wv[3]);
        pt.accel_x = blend_axis(0, wa[0], wa[1], wa[2], wa[3]);
        pt.accel_y = blend_axis(1, wa[0], wa[1], wa[2], wa[3]);
        return pt;
    endfunction

    function automatic curve_point_t pack_point(input logic [CW-1:0] px, py, vx, vy, ax, ay);
        curve_point_t pt;
        pt.pos_x   = px;
        pt.pos_y   = py;
        pt.vel_x   = vx;
        pt.vel_y   = vy;
        pt.accel_x = ax;
        pt.accel_y = ay;
        return pt;
    endfunction

    function automatic void add_write(input int idx, input logic [CW-1:0] data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.idx = IDX_W'(idx);
        row.data = data;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_item(input int param, input logic typed,
                                     input curve_point_t want);
        stim_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.param = PARAM_W'(param);
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [CW-1:0] pick_coord();
        int v;
        case ($urandom_range(0, 9))
            0: return COORD_HI;
            1: return COORD_LO;
            2, 3, 4: return $urandom();
            default:
            begin
                // within +-8.0
                v = int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
                return v;
            end
        endcase
    endfunction

    function automatic logic [PARAM_W-1:0] pick_param();
        logic [PARAM_W-1:0] p;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: p = '0;
                    1: p = PARAM_W'(1);
                    2: p = PARAM_W'(PARAM_ONE - 1);
                    3: p = PARAM_W'(PARAM_ONE);
                    4: p = PARAM_W'(PARAM_ONE + 1);
                    default: p = PARAM_W'(PARAM_MAX);
                endcase
            end
            // above 1.0, clamped by the block
            1, 2: p = PARAM_W'($urandom_range(PARAM_ONE + 1, PARAM_MAX));
            default: p = PARAM_W'($urandom_range(0, PARAM_ONE));
        endcase
        return p;
    endfunction

    task automatic write_reg(input int idx, input logic [CW-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = IDX_W'(idx);
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx < chb_pkg::NUM_REGS)
            segment_regs[idx] = data;
    endtask

    task automatic send_request(input logic [PARAM_W-1:0] param, input curve_point_t want);
        @(negedge clk);
        in_valid = 1'b1;
        curve_param = param;
        do
            @(posedge clk);
        while (!in_ready);
        expected_points.push_back(want);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_points.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic signed [CW-1:0] want,
                               input logic signed [CW-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        curve_point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                check_field("pos_x", want.pos_x, pos_x);
                check_field("pos_y", want.pos_y, pos_y);
                check_field("vel_x", want.vel_x, vel_x);
                check_field("vel_y", want.vel_y, vel_y);
                check_field("accel_x", want.accel_x, accel_x);
                check_field("accel_y", want.accel_y, accel_y);
            end
        end
    end

    initial
    begin : receiver
        ready_mode_t mode;
        int          span;
        int          tick;
        out_ready = 1'b0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            mode = ready_mode_t'($urandom_range(0, 3));
            span = $urandom_range(10, 150);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    READY_FREE:   out_ready = 1'b1;
                    READY_COIN:   out_ready = 1'($urandom_range(0, 1));
                    READY_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
                    default:      out_ready = (tick % 7) >= 3;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t    row;
        curve_point_t zero_point;
        int           burst_left;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        curve_param = '0;
        mismatch_count = 0;
        zero_point = '0;
        for (int i = 0; i < chb_pkg::NUM_REGS; i++)
            segment_regs[i] = '0;

        // after reset every output is zero, clamped t included
        add_item(0, 1'b1, zero_point);
        add_item(PARAM_MAX, 1'b1, zero_point);
        // unit start point alone
        add_write(chb_pkg::REG_START_X, 32'h0001_0000);
        add_item(0, 1'b1, pack_point(32'h0001_0000, 0, 0, 0, 32'hFFFA_0000, 0));
        add_item(PARAM_ONE, 1'b1, pack_point(0, 0, 0, 0, 32'h0006_0000, 0));
        add_item(PARAM_ONE / 2, 1'b0, zero_point);
        // largest and smallest start point, acceleration saturates
        add_write(chb_pkg::REG_START_X, COORD_HI);
        add_item(0, 1'b1, pack_point(COORD_HI, 0, 0, 0, COORD_LO, 0));
        add_item(PARAM_ONE, 1'b1, pack_point(0, 0, 0, 0, COORD_HI, 0));
        add_write(chb_pkg::REG_START_X, COORD_LO);
        add_item(0, 1'b1, pack_point(COORD_LO, 0, 0, 0, COORD_HI, 0));
        add_write(chb_pkg::REG_START_Y, 32'h0003_0000);
        add_write(chb_pkg::REG_START_TAN_X, COORD_HI);
        add_write(chb_pkg::REG_START_TAN_Y, COORD_LO);
        add_write(chb_pkg::REG_END_X, 32'hFFFF_8000);
        add_write(chb_pkg::REG_END_Y, 32'h1234_5678);
        add_write(chb_pkg::REG_END_TAN_X, 32'h0000_0001);
        add_write(chb_pkg::REG_END_TAN_Y, 32'hFFFF_FFFF);
        add_item(0, 1'b0, zero_point);
        add_item(1, 1'b0, zero_point);
        add_item(PARAM_ONE - 1, 1'b0, zero_point);
        add_item(PARAM_ONE, 1'b0, zero_point);
        add_item(PARAM_ONE + 1, 1'b0, zero_point);
        add_item(PARAM_ONE / 2, 1'b0, zero_point);
        // writes past the register map must leave the segment alone
        add_write(chb_pkg::NUM_REGS, 32'hDEAD_BEEF);
        add_write(INDEX_MAX, 32'h0000_0000);
        add_item(21845, 1'b0, zero_point);
        add_item(PARAM_MAX - 1, 1'b0, zero_point);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(int'(row.idx), row.data);
            end
            else
                send_request(row.param, row.typed ? row.want : evaluate_segment(row.param));
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // new segment only once the pipeline is empty
            wait_drained();
            for (int r = 0; r < chb_pkg::NUM_REGS; r++)
            begin
                case (phase)
                    0: write_reg(r, COORD_HI);
                    1: write_reg(r, COORD_LO);
                    2: write_reg(r, (r % 2 == 0) ? COORD_HI : COORD_LO);
                    default: write_reg(r, pick_coord());
                endcase
            end
            if ($urandom_range(0, 1) == 1)
                write_reg(int'($urandom_range(chb_pkg::NUM_REGS, INDEX_MAX)), $urandom());

            burst_left = $urandom_range(1, 24);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                logic [PARAM_W-1:0] param;
                param = pick_param();
                send_request(param, evaluate_segment(param));
                burst_left--;
                if (burst_left == 0)
                begin
                    @(negedge clk);
                    in_valid = 1'b0;
                    if ($urandom_range(0, 7) == 0)
                        repeat ($urandom_range(20, 40)) @(negedge clk);
                    else
                        repeat ($urandom_range(0, 6)) @(negedge clk);
                    burst_left = $urandom_range(1, 24);
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hdl/chb_pkg.sv
hdl/chb_param.sv
hdl/chb_basis.sv
hdl/chb_axis.sv
hdl/cubic_hermite_evaluator.sv
hdl/chb_checker.sv
tb/sv/testbench.sv
